// ===== rtl/qra_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion rotation accumulator package
// Shared constants, sequencer states and operand tables for the iterative
// quaternion update and rotation matrix datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package qra_pkg;

  // Default number of fraction bits of the fixed point format.
  localparam int QRA_FRAC_BITS = 30;

  // Last row of the rotation matrix.
  localparam logic [1:0] ROW_LAST = 2'd2;

  // Quaternion component positions in the store.
  localparam logic [1:0] C_S = 2'd0;
  localparam logic [1:0] C_X = 2'd1;
  localparam logic [1:0] C_Y = 2'd2;
  localparam logic [1:0] C_Z = 2'd3;

  // Positions of the rounded matrix products.
  localparam logic [3:0] M_YY = 4'd0;
  localparam logic [3:0] M_ZZ = 4'd1;
  localparam logic [3:0] M_XY = 4'd2;
  localparam logic [3:0] M_ZS = 4'd3;
  localparam logic [3:0] M_XZ = 4'd4;
  localparam logic [3:0] M_YS = 4'd5;
  localparam logic [3:0] M_XX = 4'd6;
  localparam logic [3:0] M_YZ = 4'd7;
  localparam logic [3:0] M_XS = 4'd8;
  localparam logic [3:0] M_LAST = M_XS;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PROD  = 9'b000000010,
    S_ZCHK  = 9'b000000100,
    S_NORM  = 9'b000001000,
    S_SQSUM = 9'b000010000,
    S_SQRT  = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_MAT   = 9'b010000000,
    S_OUT   = 9'b100000000
  } qra_state_t;

  // Sign of a Hamilton product term: component c, term t (stored part t).
  function automatic logic prod_neg(input logic [1:0] c, input logic [1:0] t);
    logic n;
    n = 1'b0;
    case (c)
      2'd0: n = (t != 2'd0);
      2'd1: n = (t == 2'd3);
      2'd2: n = (t == 2'd1);
      2'd3: n = (t == 2'd2);
      default: n = 1'b0;
    endcase
    return n;
  endfunction

  // First operand of a matrix product.
  function automatic logic [1:0] mat_a_idx(input logic [3:0] k);
    logic [1:0] r;
    r = C_S;
    case (k)
      M_YY: r = C_Y;
      M_ZZ: r = C_Z;
      M_XY: r = C_X;
      M_ZS: r = C_Z;
      M_XZ: r = C_X;
      M_YS: r = C_Y;
      M_XX: r = C_X;
      M_YZ: r = C_Y;
      M_XS: r = C_X;
      default: r = C_S;
    endcase
    return r;
  endfunction

  // Second operand of a matrix product.
  function automatic logic [1:0] mat_b_idx(input logic [3:0] k);
    logic [1:0] r;
    r = C_S;
    case (k)
      M_YY: r = C_Y;
      M_ZZ: r = C_Z;
      M_XY: r = C_Y;
      M_ZS: r = C_S;
      M_XZ: r = C_Z;
      M_YS: r = C_S;
      M_XX: r = C_X;
      M_YZ: r = C_Z;
      M_XS: r = C_S;
      default: r = C_S;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/qra_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 32 by 32 multiplier with a registered 64-bit product, used for
// every product of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module qra_mul (
  input  wire logic               clk,
  input  wire logic signed [31:0] op_a,
  input  wire logic signed [31:0] op_b,
  output logic signed [63:0]      prod_r
);

  // Product is captured every cycle; the sequencer holds the operands until it uses the product.
  always_ff @(posedge clk) begin
    prod_r <= 64'(op_a) * 64'(op_b);
  end

endmodule

`default_nettype wire

// ===== rtl/quaternion_rotation_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// Quaternion rotation accumulator core
// Multiplies the stored orientation by a delta quaternion, normalizes it and
// returns the three rows of its rotation matrix; a zero-length product keeps the old orientation.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one delta quaternion word (w, i, j, k). The
//   result channel returns three words, rows 0 to 2 of the rotation matrix
//   of the new orientation, each carrying that orientation, the zero-length
//   flag and a last-row mark on row 2.
//   The shared multiplier computes every product (16 for the product, 4 for
//   the sum of squares, 9 for the matrix), the normalizing shift moves one
//   bit a cycle, the square root takes 32 steps and each of the four
//   divisions loads its dividend and then runs one restoring step per
//   quotient bit. A zero-length product skips the normalization, root and
//   divisions.
//   Throughput: one word per run; in_ready is high only while idle, so the
//   next word is taken the cycle after row 2 is taken.
//   Reset clears the stored orientation to zero, which the first word
//   turns into the identity. If the receiver stalls, the current row holds
//   on the outputs until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_rotation_accumulator_core #(
  parameter int FRAC_BITS = qra_pkg::QRA_FRAC_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_delta_w,
  input  wire logic signed [31:0] in_delta_i,
  input  wire logic signed [31:0] in_delta_j,
  input  wire logic signed [31:0] in_delta_k,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_row_index,
  output logic signed [31:0]      out_entry_col0,
  output logic signed [31:0]      out_entry_col1,
  output logic signed [31:0]      out_entry_col2,
  output logic signed [31:0]      out_orient_w,
  output logic signed [31:0]      out_orient_i,
  output logic signed [31:0]      out_orient_j,
  output logic signed [31:0]      out_orient_k,
  output logic                    out_zero_length,
  output logic                    out_last_row
);

  import qra_pkg::*;

  localparam logic signed [63:0] ONE      = 64'sd1 << FRAC_BITS;
  localparam logic        [63:0] HALF_LSB = 64'd1 << (FRAC_BITS - 1);

  // Round to nearest at the binary point, half away from zero.
  function automatic logic signed [63:0] rnd(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [63:0] m;
    mag = p[63] ? 64'(-p) : 64'(p);
    m   = (mag + HALF_LSB) >> FRAC_BITS;
    return p[63] ? -$signed(m) : $signed(m);
  endfunction

  // Divide by four, truncating toward zero.
  function automatic logic signed [63:0] trunc4(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p[63] ? -((-p) >>> 2) : (p >>> 2);
    return t;
  endfunction

  // Saturate to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647)       r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

  qra_state_t         state_r, state_nxt;
  logic signed [31:0] q_r [4];
  logic signed [31:0] q_nxt [4];
  logic signed [31:0] d_r [4];
  logic signed [31:0] d_nxt [4];
  logic signed [63:0] acc_r [4];
  logic signed [63:0] acc_nxt [4];
  logic [63:0]        m_r [4];
  logic [63:0]        m_nxt [4];
  logic [3:0]         neg_r, neg_nxt;
  logic signed [63:0] mat_r [9];
  logic signed [63:0] mat_nxt [9];
  logic [4:0]         cnt_r, cnt_nxt;
  logic               ph_r, ph_nxt;
  logic [1:0]         comp_r, comp_nxt;
  logic [63:0]        sum_r, sum_nxt;
  logic [63:0]        n_r, n_nxt;
  logic [63:0]        root_r, root_nxt;
  logic [63:0]        bit_r, bit_nxt;
  logic [31:0]        len_r, len_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [31:0]        low_r, low_nxt;
  logic [31:0]        quo_r, quo_nxt;
  logic               zero_r, zero_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [1:0]         row_r, row_nxt;
  logic signed [31:0] ent_r [3];
  logic signed [31:0] ent_nxt [3];

  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod;

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      S_PROD: begin
        op_a = q_r[cnt_r[1:0]];
        op_b = d_r[cnt_r[3:2] ^ cnt_r[1:0]];
      end
      S_SQSUM: begin
        op_a = m_r[cnt_r[1:0]][31:0];
        op_b = m_r[cnt_r[1:0]][31:0];
      end
      S_MAT: begin
        op_a = q_r[mat_a_idx(cnt_r[3:0])];
        op_b = q_r[mat_b_idx(cnt_r[3:0])];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  qra_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod)
  );

  // Sequencer and datapath next-state logic.
  always_comb begin
    logic signed [63:0] term;
    logic [63:0]        or_m;
    logic [63:0]        tst;
    logic [63:0]        root_new;
    logic [63:0]        num;
    logic [32:0]        r2;
    logic               ge;
    logic [31:0]        qn;
    logic [31:0]        qs;
    logic [1:0]         rsel;
    logic               load_row;
    logic signed [63:0] e0, e1, e2;

    state_nxt  = state_r;
    q_nxt      = q_r;
    d_nxt      = d_r;
    acc_nxt    = acc_r;
    m_nxt      = m_r;
    neg_nxt    = neg_r;
    mat_nxt    = mat_r;
    cnt_nxt    = cnt_r;
    ph_nxt     = ph_r;
    comp_nxt   = comp_r;
    sum_nxt    = sum_r;
    n_nxt      = n_r;
    root_nxt   = root_r;
    bit_nxt    = bit_r;
    len_nxt    = len_r;
    rem_nxt    = rem_r;
    low_nxt    = low_r;
    quo_nxt    = quo_r;
    zero_nxt   = zero_r;
    ovalid_nxt = ovalid_r;
    row_nxt    = row_r;
    ent_nxt    = ent_r;
    term       = '0;
    or_m       = m_r[0] | m_r[1] | m_r[2] | m_r[3];
    tst        = root_r + bit_r;
    root_new   = '0;
    num        = (m_r[comp_r] << FRAC_BITS) + {33'd0, len_r[31:1]};
    r2         = {rem_r, low_r[31]};
    ge         = (r2 >= {1'b0, len_r});
    qn         = {quo_r[30:0], ge};
    qs         = qn[31] ? 32'h7FFFFFFF : qn;
    rsel       = 2'd0;
    load_row   = 1'b0;
    e0         = '0;
    e1         = '0;
    e2         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          d_nxt[0] = in_delta_w;
          d_nxt[1] = in_delta_i;
          d_nxt[2] = in_delta_j;
          d_nxt[3] = in_delta_k;
          // An all-zero orientation starts out as the identity.
          if (q_r[0] == '0 && q_r[1] == '0 && q_r[2] == '0 && q_r[3] == '0) begin
            q_nxt[0] = ONE[31:0];
          end
          for (int i = 0; i < 4; i++) acc_nxt[i] = '0;
          cnt_nxt   = '0;
          ph_nxt    = 1'b0;
          state_nxt = S_PROD;
        end
      end
      S_PROD: begin
        // Hamilton product; each term is accumulated once the registered product is ready.
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          term   = trunc4(prod);
          if (prod_neg(cnt_r[3:2], cnt_r[1:0])) begin
            acc_nxt[cnt_r[3:2]] = acc_r[cnt_r[3:2]] - term;
          end else begin
            acc_nxt[cnt_r[3:2]] = acc_r[cnt_r[3:2]] + term;
          end
          if (cnt_r == 5'd15) state_nxt = S_ZCHK;
          else cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_ZCHK: begin
        for (int i = 0; i < 4; i++) begin
          m_nxt[i]   = acc_r[i][63] ? 64'(-acc_r[i]) : 64'(acc_r[i]);
          neg_nxt[i] = acc_r[i][63];
        end
        zero_nxt = (acc_r[0] == '0 && acc_r[1] == '0 && acc_r[2] == '0 && acc_r[3] == '0);
        cnt_nxt  = '0;
        ph_nxt   = 1'b0;
        if (zero_nxt) state_nxt = S_MAT;
        else state_nxt = S_NORM;
      end
      S_NORM: begin
        // Shift all magnitudes together until the largest has its top bit at 29.
        if (or_m[63:30] != '0) begin
          for (int i = 0; i < 4; i++) m_nxt[i] = m_r[i] >> 1;
        end else if (!or_m[29]) begin
          for (int i = 0; i < 4; i++) m_nxt[i] = m_r[i] << 1;
        end else begin
          cnt_nxt   = '0;
          ph_nxt    = 1'b0;
          sum_nxt   = '0;
          state_nxt = S_SQSUM;
        end
      end
      S_SQSUM: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt  = 1'b0;
          sum_nxt = sum_r + $unsigned(prod);
          if (cnt_r == 5'd3) begin
            n_nxt     = sum_r + $unsigned(prod);
            root_nxt  = '0;
            bit_nxt   = 64'd1 << 62;
            cnt_nxt   = '0;
            state_nxt = S_SQRT;
          end else begin
            cnt_nxt = cnt_r + 5'd1;
          end
        end
      end
      S_SQRT: begin
        // Digit-by-digit integer square root, two bits of radicand a step.
        if (n_r >= tst) begin
          n_nxt    = n_r - tst;
          root_new = (root_r >> 1) + bit_r;
        end else begin
          root_new = root_r >> 1;
        end
        root_nxt = root_new;
        bit_nxt  = bit_r >> 2;
        if (cnt_r == 5'd31) begin
          len_nxt   = root_new[31:0];
          comp_nxt  = '0;
          ph_nxt    = 1'b0;
          state_nxt = S_DIV;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_DIV: begin
        // Restoring division of the scaled magnitude by the length.
        if (!ph_r) begin
          rem_nxt = num[63:32];
          low_nxt = num[31:0];
          quo_nxt = '0;
          cnt_nxt = '0;
          ph_nxt  = 1'b1;
        end else begin
          rem_nxt = ge ? 32'(r2 - {1'b0, len_r}) : r2[31:0];
          low_nxt = low_r << 1;
          quo_nxt = qn;
          if (cnt_r == 5'd31) begin
            q_nxt[comp_r] = neg_r[comp_r] ? -$signed(qs) : $signed(qs);
            ph_nxt        = 1'b0;
            if (comp_r == 2'd3) begin
              cnt_nxt   = '0;
              state_nxt = S_MAT;
            end else begin
              comp_nxt = comp_r + 2'd1;
            end
          end else begin
            cnt_nxt = cnt_r + 5'd1;
          end
        end
      end
      S_MAT: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          mat_nxt[cnt_r[3:0]] = rnd(prod);
          if (cnt_r[3:0] == M_LAST) begin
            ovalid_nxt = 1'b0;
            state_nxt  = S_OUT;
          end else begin
            cnt_nxt = cnt_r + 5'd1;
          end
        end
      end
      S_OUT: begin
        // Hand out the rows; a stalled row holds.
        if (!ovalid_r) begin
          rsel       = 2'd0;
          load_row   = 1'b1;
          ovalid_nxt = 1'b1;
        end else if (out_ready) begin
          if (row_r == ROW_LAST) begin
            ovalid_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end else begin
            rsel     = row_r + 2'd1;
            load_row = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Matrix entries of the selected row.
    case (rsel)
      2'd0: begin
        e0 = ONE - ((mat_r[M_YY] + mat_r[M_ZZ]) <<< 1);
        e1 = (mat_r[M_XY] - mat_r[M_ZS]) <<< 1;
        e2 = (mat_r[M_XZ] + mat_r[M_YS]) <<< 1;
      end
      2'd1: begin
        e0 = (mat_r[M_XY] + mat_r[M_ZS]) <<< 1;
        e1 = ONE - ((mat_r[M_XX] + mat_r[M_ZZ]) <<< 1);
        e2 = (mat_r[M_YZ] - mat_r[M_XS]) <<< 1;
      end
      default: begin
        e0 = (mat_r[M_XZ] - mat_r[M_YS]) <<< 1;
        e1 = (mat_r[M_YZ] + mat_r[M_XS]) <<< 1;
        e2 = ONE - ((mat_r[M_XX] + mat_r[M_YY]) <<< 1);
      end
    endcase
    if (load_row) begin
      row_nxt    = rsel;
      ent_nxt[0] = sat32(e0);
      ent_nxt[1] = sat32(e1);
      ent_nxt[2] = sat32(e2);
    end
  end

  // Control state and the orientation store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      for (int i = 0; i < 4; i++) q_r[i] <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      q_r      <= q_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    acc_r  <= acc_nxt;
    m_r    <= m_nxt;
    neg_r  <= neg_nxt;
    mat_r  <= mat_nxt;
    cnt_r  <= cnt_nxt;
    ph_r   <= ph_nxt;
    comp_r <= comp_nxt;
    sum_r  <= sum_nxt;
    n_r    <= n_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
    len_r  <= len_nxt;
    rem_r  <= rem_nxt;
    low_r  <= low_nxt;
    quo_r  <= quo_nxt;
    zero_r <= zero_nxt;
    row_r  <= row_nxt;
    ent_r  <= ent_nxt;
  end

  // Ports.
  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = ovalid_r;
  assign out_row_index   = row_r;
  assign out_entry_col0  = ent_r[0];
  assign out_entry_col1  = ent_r[1];
  assign out_entry_col2  = ent_r[2];
  assign out_orient_w    = q_r[0];
  assign out_orient_i    = q_r[1];
  assign out_orient_j    = q_r[2];
  assign out_orient_k    = q_r[3];
  assign out_zero_length = zero_r;
  assign out_last_row    = (row_r == ROW_LAST);

endmodule

`default_nettype wire

// ===== rtl/qra_checker.sv =====
// ----------------------------------------------------------------------------
// Quaternion rotation accumulator port checker
// Checks the sequencing of words seen on the ports of the core.
// ----------------------------------------------------------------------------
`default_nettype none

module qra_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_row_index,
  input wire logic       out_last_row
);

  import qra_pkg::*;

  // A stalled row keeps its index.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_index))
    else $error("stalled row changed");

  // The core is busy once a word is taken.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("core ready right after accepting a word");

  // No new word is taken while rows are pending.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("ready while rows pending");

  // The last-row mark goes with row two, after which the run ends.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_row == (out_row_index == ROW_LAST)) && (out_row_index != 2'd3))
    else $error("bad row index or last mark");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_row |=> !out_valid && in_ready)
    else $error("run did not end after the last row");

endmodule

bind quaternion_rotation_accumulator_core qra_checker u_qra_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_row_index (out_row_index),
  .out_last_row  (out_last_row)
);

`default_nettype wire
